@@ hdl/srx_pkg.sv @@
// Package for the serial frame receiver: item type, protocol constants,
// status codes and the byte-wide CRC-16 update.
// No dependencies.
`default_nettype none

package srx_pkg;

    localparam int PAYLOAD_CAPACITY = 64;

    localparam logic [7:0]  SOF_BYTE      = 8'h55;
    localparam logic [7:0]  EOF_BYTE      = 8'h0d;
    localparam logic [7:0]  LEN_HI_MASK   = 8'h7f;
    localparam logic [15:0] CRC_POLY_REFL = 16'ha001;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RECV   = 3'd1;
    localparam logic [2:0] ST_GOOD   = 3'd2;
    localparam logic [2:0] ST_CRCERR = 3'd3;
    localparam logic [2:0] ST_LENERR = 3'd4;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // classified item, as held in the queue
    typedef struct packed {
        logic       is_tick;
        logic       is_sof;
        logic       is_eof;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [15:0] crc_take_byte(input logic [15:0] crc,
                                                  input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/srx_front.sv @@
// Front end: input handshake and classification of each item.
// Depends on srx_pkg.
`default_nettype none

module srx_front (
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_func,
    input  wire  [7:0]             s_rx_byte,
    input  srx_pkg::queue_status_t q_status,
    output logic                   push,
    output srx_pkg::item_t         push_item
);

    always_comb begin
        s_ready           = !q_status.full;
        push              = s_valid && !q_status.full;
        push_item.is_tick = (s_func == srx_pkg::FUNC_TICK);
        push_item.is_sof  = (s_func == srx_pkg::FUNC_BYTE) && (s_rx_byte == srx_pkg::SOF_BYTE);
        push_item.is_eof  = (s_func == srx_pkg::FUNC_BYTE) && (s_rx_byte == srx_pkg::EOF_BYTE);
        push_item.data    = s_rx_byte;
    end

endmodule

`default_nettype wire

@@ hdl/srx_queue.sv @@
// Two-entry queue of classified items between front and back.
// Depends on srx_pkg.
`default_nettype none

module srx_queue (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push,
    input  srx_pkg::item_t         push_item,
    input  wire                    pop,
    output srx_pkg::item_t         pop_item,
    output srx_pkg::queue_status_t q_status
);

    srx_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        q_status.full  = (count_reg == 2'd2);
        q_status.empty = (count_reg == 2'd0);
        pop_item       = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/srx_back.sv @@
// Back end: frame parser, CRC-16 and registered result stage.
// Depends on srx_pkg.
`default_nettype none

module srx_back (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire  [15:0]            idle_timeout,
    input  srx_pkg::queue_status_t q_status,
    input  srx_pkg::item_t         pop_item,
    output logic                   pop,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [2:0]             m_status,
    output logic [15:0]            m_frame_id,
    output logic [14:0]            m_frame_length,
    output logic                   m_payload_valid,
    output logic [7:0]             m_payload_byte,
    output logic [5:0]             m_payload_index
);

    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_ID_HI  = 4'd1;
    localparam logic [3:0] PH_ID_LO  = 4'd2;
    localparam logic [3:0] PH_LEN_HI = 4'd3;
    localparam logic [3:0] PH_LEN_LO = 4'd4;
    localparam logic [3:0] PH_DATA   = 4'd5;
    localparam logic [3:0] PH_CRC_HI = 4'd6;
    localparam logic [3:0] PH_CRC_LO = 4'd7;
    localparam logic [3:0] PH_EOF    = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] id_reg, id_next;
    logic [14:0] length_reg, length_next;
    logic [6:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_run_reg, crc_run_next;
    logic [15:0] crc_rx_reg, crc_rx_next;
    logic [15:0] idle_count_reg, idle_count_next;
    logic        out_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic        pv_reg, pv_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [5:0]  pidx_reg, pidx_next;

    logic [15:0] crc_upd;
    logic [3:0]  phase_cur;
    logic [14:0] len_full;
    logic [6:0]  count_inc;

    always_comb begin
        pop       = !q_status.empty && (!out_valid_reg || m_ready);
        crc_upd   = srx_pkg::crc_take_byte(crc_run_reg, pop_item.data);
        phase_cur = (phase_reg > PH_EOF) ? PH_HUNT : phase_reg;
        len_full  = {length_reg[14:8], pop_item.data};
        count_inc = byte_count_reg + 7'd1;

        phase_next      = phase_cur;
        id_next         = id_reg;
        length_next     = length_reg;
        byte_count_next = byte_count_reg;
        crc_run_next    = crc_run_reg;
        crc_rx_next     = crc_rx_reg;
        idle_count_next = 16'd0;
        status_next     = srx_pkg::ST_RECV;
        pv_next         = 1'b0;
        pbyte_next      = 8'd0;
        pidx_next       = 6'd0;

        if (pop_item.is_tick) begin
            idle_count_next = idle_count_reg + 16'd1;
            if (idle_count_next >= idle_timeout) begin
                idle_count_next = 16'd0;
                phase_next      = PH_HUNT;
            end
            status_next = (phase_next == PH_HUNT) ? srx_pkg::ST_IDLE : srx_pkg::ST_RECV;
        end else begin
            case (phase_cur)
                PH_ID_HI: begin
                    id_next      = {pop_item.data, 8'd0};
                    crc_run_next = crc_upd;
                    phase_next   = PH_ID_LO;
                end
                PH_ID_LO: begin
                    id_next      = {id_reg[15:8], pop_item.data};
                    crc_run_next = crc_upd;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    length_next  = {pop_item.data[6:0] & srx_pkg::LEN_HI_MASK[6:0], 8'd0};
                    crc_run_next = crc_upd;
                    phase_next   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next     = len_full;
                    crc_run_next    = crc_upd;
                    byte_count_next = 7'd0;
                    if (len_full == 15'd0) begin
                        phase_next = PH_CRC_HI;
                    end else if (len_full > 15'(srx_pkg::PAYLOAD_CAPACITY)) begin
                        status_next = srx_pkg::ST_LENERR;
                        phase_next  = PH_HUNT;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    pv_next         = 1'b1;
                    pbyte_next      = pop_item.data;
                    pidx_next       = byte_count_reg[5:0];
                    crc_run_next    = crc_upd;
                    byte_count_next = count_inc;
                    if ({8'd0, count_inc} >= length_reg) begin
                        phase_next = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    crc_rx_next = {pop_item.data, 8'd0};
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    crc_rx_next = {crc_rx_reg[15:8], pop_item.data};
                    phase_next  = PH_EOF;
                end
                PH_EOF: begin
                    if (pop_item.is_eof) begin
                        status_next = (crc_run_reg == crc_rx_reg) ?
                                      srx_pkg::ST_GOOD : srx_pkg::ST_CRCERR;
                        phase_next  = PH_HUNT;
                    end
                end
                default: begin
                    if (pop_item.is_sof) begin
                        id_next         = 16'd0;
                        length_next     = 15'd0;
                        byte_count_next = 7'd0;
                        crc_rx_next     = 16'd0;
                        crc_run_next    = srx_pkg::crc_take_byte(16'd0, pop_item.data);
                        phase_next      = PH_ID_HI;
                    end else begin
                        status_next = srx_pkg::ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            id_reg         <= 16'd0;
            length_reg     <= 15'd0;
            byte_count_reg <= 7'd0;
            crc_run_reg    <= 16'd0;
            crc_rx_reg     <= 16'd0;
            idle_count_reg <= 16'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg      <= phase_next;
                id_reg         <= id_next;
                length_reg     <= length_next;
                byte_count_reg <= byte_count_next;
                crc_run_reg    <= crc_run_next;
                crc_rx_reg     <= crc_rx_next;
                idle_count_reg <= idle_count_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            pv_reg     <= pv_next;
            pbyte_reg  <= pbyte_next;
            pidx_reg   <= pidx_next;
        end
    end

    always_comb begin
        m_valid         = out_valid_reg;
        m_status        = status_reg;
        m_frame_id      = id_reg;
        m_frame_length  = length_reg;
        m_payload_valid = pv_reg;
        m_payload_byte  = pbyte_reg;
        m_payload_index = pidx_reg;
    end

endmodule

`default_nettype wire

@@ hdl/serial_frame_receiver_crc16.sv @@
// Top level of the serial frame receiver: config register, front end,
// item queue and parser back end. Depends on srx_pkg, srx_front,
// srx_queue and srx_back.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_func, s_rx_byte
//   m_       out        m_valid / m_ready  m_status, m_frame_id, m_frame_length,
//                                          m_payload_valid, m_payload_byte,
//                                          m_payload_index
//   apb      in         psel/penable/pready idle_timeout at address 0
//
// One item per cycle sustained while m_ready keeps up; a taken item is held
// in the two-entry queue and then in the registered result stage.
// Reset (aresetn low, synchronous) returns the parser to hunting and the
// timeout to 10000. A stalled m_ready holds the result register; the queue
// absorbs two more items before s_ready drops.
`default_nettype none

module serial_frame_receiver_crc16 (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_func,
    input  wire  [7:0]  s_rx_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_frame_id,
    output logic [14:0] m_frame_length,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_payload_index,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]            idle_timeout_reg;
    logic                   cfg_wr;
    srx_pkg::queue_status_t q_status;
    srx_pkg::item_t         push_item;
    srx_pkg::item_t         pop_item;
    logic                   push;
    logic                   pop;

    always_comb begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
        prdata = (paddr[2] == 1'b0) ? {16'd0, idle_timeout_reg} : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= srx_pkg::TIMEOUT_RESET;
        end else if (cfg_wr) begin
            idle_timeout_reg <= pwdata[15:0];
        end
    end

    srx_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_rx_byte (s_rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    srx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    srx_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .idle_timeout    (idle_timeout_reg),
        .q_status        (q_status),
        .pop_item        (pop_item),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_frame_id      (m_frame_id),
        .m_frame_length  (m_frame_length),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for serial_frame_receiver_crc16: frames, noise and idle ticks are
// sent through the s_ channel and every m_ item is checked against a predictor.
// Depends on srx_pkg and the receiver RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd0;

    localparam logic [3:0] HUNT_SOF   = 4'd0;
    localparam logic [3:0] GET_ID_HI  = 4'd1;
    localparam logic [3:0] GET_ID_LO  = 4'd2;
    localparam logic [3:0] GET_LEN_HI = 4'd3;
    localparam logic [3:0] GET_LEN_LO = 4'd4;
    localparam logic [3:0] GET_DATA   = 4'd5;
    localparam logic [3:0] GET_CRC_HI = 4'd6;
    localparam logic [3:0] GET_CRC_LO = 4'd7;
    localparam logic [3:0] WAIT_EOF   = 4'd8;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] id;
        logic [14:0] len;
        logic        pv;
        logic [7:0]  pbyte;
        logic [5:0]  pidx;
    } rx_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = srx_pkg::FUNC_BYTE;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_frame_id;
    logic [14:0] m_frame_length;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [5:0]  m_payload_index;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    serial_frame_receiver_crc16 uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_frame_id(m_frame_id), .m_frame_length(m_frame_length),
        .m_payload_valid(m_payload_valid), .m_payload_byte(m_payload_byte),
        .m_payload_index(m_payload_index),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [3:0]  m_phase = HUNT_SOF;
    logic [15:0] m_id = '0;
    logic [14:0] m_len = '0;
    logic [6:0]  m_cnt = '0;
    logic [15:0] m_crc = '0;
    logic [15:0] m_crc_rx = '0;
    logic [15:0] m_idle_cnt = '0;
    logic [15:0] m_timeout = srx_pkg::TIMEOUT_RESET;

    rx_result_t pending_results[$];

    int error_count = 0;
    int items_sent = 0;
    int n_checked = 0;
    int n_good = 0;
    int n_crcerr = 0;
    int n_lenerr = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_cnt = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(5_000_000);
        $display("tb_top: timeout with %0d results outstanding", pending_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [15:0] crc16_arc_update(input logic [15:0] crc,
                                                     input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ srx_pkg::CRC_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    function automatic rx_result_t predict_rx(input logic func, input logic [7:0] b);
        rx_result_t r;
        logic [7:0] hi;
        r = '0;
        r.status = srx_pkg::ST_RECV;
        if (func == srx_pkg::FUNC_TICK) begin
            m_idle_cnt = m_idle_cnt + 16'd1;
            if (m_idle_cnt >= m_timeout) begin
                m_idle_cnt = '0;
                m_phase = HUNT_SOF;
            end
            r.status = (m_phase == HUNT_SOF) ? srx_pkg::ST_IDLE : srx_pkg::ST_RECV;
        end else begin
            m_idle_cnt = '0;
            case (m_phase)
                GET_ID_HI: begin
                    m_id = {b, 8'h00};
                    m_crc = crc16_arc_update(m_crc, b);
                    m_phase = GET_ID_LO;
                end
                GET_ID_LO: begin
                    m_id[7:0] = b;
                    m_crc = crc16_arc_update(m_crc, b);
                    m_phase = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    hi = b & srx_pkg::LEN_HI_MASK;
                    m_len = {hi[6:0], 8'h00};
                    m_crc = crc16_arc_update(m_crc, b);
                    m_phase = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    m_len[7:0] = b;
                    m_crc = crc16_arc_update(m_crc, b);
                    m_cnt = '0;
                    if (m_len == '0) begin
                        m_phase = GET_CRC_HI;
                    end else if (m_len > srx_pkg::PAYLOAD_CAPACITY) begin
                        r.status = srx_pkg::ST_LENERR;
                        m_phase = HUNT_SOF;
                    end else begin
                        m_phase = GET_DATA;
                    end
                end
                GET_DATA: begin
                    r.pv = 1'b1;
                    r.pbyte = b;
                    r.pidx = m_cnt[5:0];
                    m_crc = crc16_arc_update(m_crc, b);
                    m_cnt = m_cnt + 7'd1;
                    if (m_cnt >= m_len) m_phase = GET_CRC_HI;
                end
                GET_CRC_HI: begin
                    m_crc_rx = {b, 8'h00};
                    m_phase = GET_CRC_LO;
                end
                GET_CRC_LO: begin
                    m_crc_rx[7:0] = b;
                    m_phase = WAIT_EOF;
                end
                WAIT_EOF: begin
                    if (b == srx_pkg::EOF_BYTE) begin
                        r.status = (m_crc == m_crc_rx) ? srx_pkg::ST_GOOD
                                                       : srx_pkg::ST_CRCERR;
                        m_phase = HUNT_SOF;
                    end
                end
                default: begin
                    if (b == srx_pkg::SOF_BYTE) begin
                        m_id = '0;
                        m_len = '0;
                        m_cnt = '0;
                        m_crc_rx = '0;
                        m_crc = crc16_arc_update(16'h0000, b);
                        m_phase = GET_ID_HI;
                    end else begin
                        r.status = srx_pkg::ST_IDLE;
                    end
                end
            endcase
        end
        r.id = m_id;
        r.len = m_len;
        return r;
    endfunction

    // result receiver: random stalls plus requested long hold-offs
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cnt > 0) begin
                m_ready <= 1'b0;
                hold_cnt = hold_cnt - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        rx_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, m_status);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("status", exp_r.status, m_status);
                check_field("frame_id", exp_r.id, m_frame_id);
                check_field("frame_length", exp_r.len, m_frame_length);
                check_field("payload_valid", exp_r.pv, m_payload_valid);
                check_field("payload_byte", exp_r.pbyte, m_payload_byte);
                check_field("payload_index", exp_r.pidx, m_payload_index);
                n_checked++;
                if (exp_r.status == srx_pkg::ST_GOOD) n_good++;
                if (exp_r.status == srx_pkg::ST_CRCERR) n_crcerr++;
                if (exp_r.status == srx_pkg::ST_LENERR) n_lenerr++;
            end
        end
    end

    // leaves s_valid high on return; the next call or sender_rest decides
    task automatic send_item(input logic func, input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_rx(func, b));
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) send_item(srx_pkg::FUNC_TICK, 8'($urandom));
    endtask

    task automatic sender_rest();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        sender_rest();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        logic [31:0] rd;
        drain();
        apb_write(REG_IDLE_TIMEOUT, {16'h0000, v});
        m_timeout = v;
        apb_read(REG_IDLE_TIMEOUT, rd);
        check_field("idle_timeout readback", {16'h0000, m_timeout}, rd);
    endtask

    // header and payload in hb; CRC, stray bytes and end byte appended here
    task automatic send_frame_bytes(input logic [7:0] hb[$], input logic [15:0] crc_flip,
                                    input int junk_eof, input int cut, input int tick_pct);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        logic [7:0]  j;
        int          n;
        int          run;
        crc = 16'h0000;
        fb = hb;
        foreach (hb[i]) crc = crc16_arc_update(crc, hb[i]);
        crc = crc ^ crc_flip;
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        for (int i = 0; i < junk_eof; i++) begin
            do j = 8'($urandom); while (j == srx_pkg::EOF_BYTE);
            fb.push_back(j);
        end
        fb.push_back(srx_pkg::EOF_BYTE);
        n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < tick_pct) begin
                run = $urandom_range(1, 3);
                if (m_timeout < 16 && $urandom_range(3) == 0) run = m_timeout;
                send_ticks(run);
            end
            send_item(srx_pkg::FUNC_BYTE, fb[i]);
        end
    endtask

    task automatic send_random_frame(input int tick_pct);
        logic [7:0]  hb[$];
        logic [15:0] id;
        logic [14:0] len;
        logic [15:0] flip;
        int          sel;
        int          body;
        int          junk;
        int          cut;
        sel = $urandom_range(99);
        id = 16'($urandom);
        if (sel < 6) len = 15'($urandom_range(srx_pkg::PAYLOAD_CAPACITY + 1, 32767));
        else if (sel < 12) len = '0;
        else if (sel < 16) len = 15'(srx_pkg::PAYLOAD_CAPACITY);
        else len = 15'($urandom_range(1, 12));
        body = (len <= srx_pkg::PAYLOAD_CAPACITY) ? int'(len) : 0;
        hb = {srx_pkg::SOF_BYTE, id[15:8], id[7:0], {1'($urandom), len[14:8]}, len[7:0]};
        for (int i = 0; i < body; i++) hb.push_back(8'($urandom));
        flip = ($urandom_range(99) < 20) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        junk = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
        cut = ($urandom_range(99) < 8) ? $urandom_range(1, body + 7) : 0;
        if (len > srx_pkg::PAYLOAD_CAPACITY) cut = 5;
        send_frame_bytes(hb, flip, junk, cut, tick_pct);
    endtask

    task automatic run_random_phase(input int n_items, input int tick_pct);
        int start;
        int sel;
        start = items_sent;
        while (items_sent - start < n_items) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                repeat ($urandom_range(1, 3)) send_item(srx_pkg::FUNC_BYTE, 8'($urandom));
            end else if (sel < 25) begin
                send_ticks((m_timeout < 16) ? $urandom_range(1, m_timeout + 2)
                                            : $urandom_range(1, 5));
            end
            send_random_frame(tick_pct);
        end
    endtask

    task automatic test_register_access();
        logic [31:0] rd;
        apb_read(REG_IDLE_TIMEOUT, rd);
        check_field("idle_timeout reset", {16'h0000, srx_pkg::TIMEOUT_RESET}, rd);
        set_timeout(16'hffff);
        set_timeout(16'h0001);
        set_timeout(16'h0000);
        set_timeout(srx_pkg::TIMEOUT_RESET);
    endtask

    task automatic test_directed_frames();
        logic [7:0] hb[$];
        send_item(srx_pkg::FUNC_BYTE, 8'h00);
        send_item(srx_pkg::FUNC_TICK, 8'hff);
        // zero length, bit 7 of length high set, one stray byte before the end
        hb = {srx_pkg::SOF_BYTE, 8'hff, 8'hff, 8'h80, 8'h00};
        send_frame_bytes(hb, 16'h0000, 1, 0, 0);
        // length just above capacity
        hb = {srx_pkg::SOF_BYTE, 8'h00, 8'h00, 8'h00, 8'h41};
        send_frame_bytes(hb, 16'h0000, 0, 5, 0);
        // extreme payload bytes, corrupted CRC
        hb = {srx_pkg::SOF_BYTE, 8'h12, 8'h34, 8'h00, 8'h02, 8'h00, 8'hff};
        send_frame_bytes(hb, 16'h0001, 0, 0, 0);
        drain();
    endtask

    task automatic test_idle_timeout();
        set_timeout(16'h0000);
        run_random_phase(150, 30);
        set_timeout(16'h0001);
        run_random_phase(150, 30);
        set_timeout(srx_pkg::TIMEOUT_RESET);
        run_random_phase(200, 10);
        drain();
    endtask

    task automatic test_random_traffic();
        send_gap_pct = 16;
        recv_stall_pct = 65;
        set_timeout(16'd5);
        run_random_phase(350, 20);
        send_gap_pct = 65;
        recv_stall_pct = 16;
        set_timeout(16'hffff);
        run_random_phase(350, 20);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        drain();
    endtask

    task automatic test_backpressure();
        logic [7:0] hb[$];
        drain();
        hold_cnt = 200;
        hb = {srx_pkg::SOF_BYTE, 8'ha5, 8'h5a, 8'h00, 8'd30};
        for (int i = 0; i < 30; i++) hb.push_back(8'($urandom));
        send_frame_bytes(hb, 16'h0000, 0, 0, 0);
        drain();
        send_random_frame(0);
        drain();
    endtask

    initial begin
        int wait_cycles;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        repeat (4) @(posedge aclk);
        send_gap_pct = 16;
        recv_stall_pct = 65;
        test_register_access();
        test_directed_frames();
        test_random_traffic();
        test_idle_timeout();
        test_backpressure();
        sender_rest();
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count++;
        end
        repeat (20) @(posedge aclk);
        $display("tb_top: %0d items sent, %0d results checked (%0d good, %0d crc, %0d length)",
                 items_sent, n_checked, n_good, n_crcerr, n_lenerr);
        $display("tb_top: timeouts 0/1/5/10000/65535, random stalls and a long output hold");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ serial_frame_receiver_crc16.f @@
hdl/srx_pkg.sv
hdl/srx_front.sv
hdl/srx_queue.sv
hdl/srx_back.sv
hdl/serial_frame_receiver_crc16.sv
test/tb_top.sv
